// ----- rtl/core/tun_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants for the triangle unit normal block
// Defines the request and result structs and the fixed arithmetic widths.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH      = 32;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_BITS        = 30;
  localparam int EDGE_W           = COORD_WIDTH + 1;
  localparam int PROD_W           = 2 * EDGE_W;
  localparam int CROSS_W          = PROD_W + 1;
  localparam int MAG_W            = CROSS_W;
  localparam int BLEN_W           = $clog2(MAG_W + 1);
  localparam int SUM_W            = 2 * NORM_BITS + 2;
  localparam int ROOT_W           = SUM_W / 2;
  localparam int NUM_W            = NORM_BITS + NORMAL_FRAC_BITS;
  localparam int QUO_W            = NUM_W + 1;
  // Covers the front pipeline plus the queue round trip at full rate
  localparam int FIFO_DEPTH       = 8;
  localparam int FIFO_AW          = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [15:0]        triangle_tag;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
  } tun_in_t;

  typedef struct packed {
    logic [15:0]        result_tag;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } tun_out_t;

  // Classified request handed from front to back: scaled magnitudes and signs
  typedef struct packed {
    logic [15:0]          tag;
    logic                 degenerate;
    logic [2:0]           neg;
    logic [NORM_BITS-1:0] mx;
    logic [NORM_BITS-1:0] my;
    logic [NORM_BITS-1:0] mz;
  } tun_job_t;

endpackage : tun_pkg
`default_nettype wire

// ----- rtl/core/tun_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tun_front: edge, cross product and normalization pipeline
// Forms the edges, the exact cross product and scales the magnitudes to a
// fixed 30-bit range. Advances only while the stage enable is high.
// ----------------------------------------------------------------------------
module tun_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire tun_pkg::tun_in_t in_data,
  output logic                  job_vld,
  output tun_pkg::tun_job_t     job
);
  import tun_pkg::*;

  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;

  logic [3:0]  vld_r;
  logic [15:0] tag1_r, tag2_r, tag3_r, tag4_r;
  edge_t       e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  prod_t       p_r [6];
  cross_t      c_r [3];
  logic [MAG_W-1:0]  mag_r [3];
  logic [2:0]        neg_r;
  logic [BLEN_W-1:0] blen_r;
  logic [MAG_W-1:0]  all_mag;
  logic [BLEN_W-1:0] blen_nxt;
  logic [MAG_W-1:0]  cmag [3];
  tun_job_t          job_r;

  function automatic edge_t sx(input logic [31:0] v);
    logic signed [COORD_WIDTH-1:0] t;
    t = v[COORD_WIDTH-1:0];
    return edge_t'(t);
  endfunction

  // Valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // Stage 1: edges; stage 2: products; stage 3: cross product
  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= in_data.triangle_tag;
      e1x_r <= sx(in_data.second_x) - sx(in_data.first_x);
      e1y_r <= sx(in_data.second_y) - sx(in_data.first_y);
      e1z_r <= sx(in_data.second_z) - sx(in_data.first_z);
      e2x_r <= sx(in_data.third_x) - sx(in_data.first_x);
      e2y_r <= sx(in_data.third_y) - sx(in_data.first_y);
      e2z_r <= sx(in_data.third_z) - sx(in_data.first_z);
      tag2_r <= tag1_r;
      p_r[0] <= e1y_r * e2z_r;
      p_r[1] <= e1z_r * e2y_r;
      p_r[2] <= e1z_r * e2x_r;
      p_r[3] <= e1x_r * e2z_r;
      p_r[4] <= e1x_r * e2y_r;
      p_r[5] <= e1y_r * e2x_r;
      tag3_r <= tag2_r;
      c_r[0] <= cross_t'(p_r[0]) - cross_t'(p_r[1]);
      c_r[1] <= cross_t'(p_r[2]) - cross_t'(p_r[3]);
      c_r[2] <= cross_t'(p_r[4]) - cross_t'(p_r[5]);
    end
  end

  // Magnitudes and common bit length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_r[i][CROSS_W-1] ? MAG_W'(-c_r[i]) : MAG_W'(c_r[i]);
    end
    all_mag  = cmag[0] | cmag[1] | cmag[2];
    blen_nxt = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (all_mag[b]) blen_nxt = BLEN_W'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag4_r <= tag3_r;
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= cmag[i];
        neg_r[i] <= c_r[i][CROSS_W-1];
      end
      blen_r <= blen_nxt;
    end
  end

  // Stage 5: scale to the normalized range
  always_ff @(posedge clk) begin
    if (en) begin
      job_r.tag        <= tag4_r;
      job_r.neg        <= neg_r;
      job_r.degenerate <= (blen_r == '0);
      if (blen_r > BLEN_W'(NORM_BITS)) begin
        job_r.mx <= NORM_BITS'(mag_r[0] >> (blen_r - BLEN_W'(NORM_BITS)));
        job_r.my <= NORM_BITS'(mag_r[1] >> (blen_r - BLEN_W'(NORM_BITS)));
        job_r.mz <= NORM_BITS'(mag_r[2] >> (blen_r - BLEN_W'(NORM_BITS)));
      end else begin
        job_r.mx <= NORM_BITS'(mag_r[0] << (BLEN_W'(NORM_BITS) - blen_r));
        job_r.my <= NORM_BITS'(mag_r[1] << (BLEN_W'(NORM_BITS) - blen_r));
        job_r.mz <= NORM_BITS'(mag_r[2] << (BLEN_W'(NORM_BITS) - blen_r));
      end
    end
  end

  logic vld5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld_r[3];
    end
  end

  assign job_vld = vld5_r;
  assign job     = job_r;

endmodule : tun_front
`default_nettype wire

// ----- rtl/core/tun_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tun_fifo: request queue between front and back
// Small register queue; reports its fill count for credit-based stalling.
// ----------------------------------------------------------------------------
module tun_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire tun_pkg::tun_job_t wr_data,
  input  wire logic              rd_en,
  output logic                   rd_vld,
  output tun_pkg::tun_job_t      rd_data,
  output logic [tun_pkg::FIFO_AW:0] count
);
  import tun_pkg::*;

  tun_job_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign count   = cnt_r;

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH)) |-> !wr_en || rd_en;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_no_underflow;
    @(posedge clk) disable iff (!rst_n) rd_en |-> rd_vld;
  endproperty
  a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

  property p_count_step;
    @(posedge clk) disable iff (!rst_n) (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 1'b1;
  endproperty
  a_count_step: assert property (p_count_step) else $error("count mismatch");

endmodule : tun_fifo
`default_nettype wire

// ----- rtl/core/tun_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tun_back: length and division pipeline
// Square root of the sum of squares one bit per stage, then three parallel
// restoring dividers one quotient bit per stage, rounding and saturation.
// ----------------------------------------------------------------------------
module tun_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              job_vld,
  input  wire tun_pkg::tun_job_t job,
  output logic                   res_vld,
  output tun_pkg::tun_out_t      res
);
  import tun_pkg::*;

  localparam int SQ_ST  = ROOT_W;
  localparam int DV_ST  = QUO_W;
  localparam int DVD_W  = NUM_W + 1;
  localparam int REM_W  = ROOT_W + 2;

  // Stage A: squares
  logic              va_r;
  tun_job_t          ja_r;
  logic [2*NORM_BITS-1:0] sq_r [3];
  // Stage B: sum
  logic              vb_r;
  tun_job_t          jb_r;
  logic [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= job_vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ja_r <= job;
      sq_r[0] <= job.mx * job.mx;
      sq_r[1] <= job.my * job.my;
      sq_r[2] <= job.mz * job.mz;
      jb_r <= ja_r;
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  // Square root: one result bit per stage, restoring
  logic [SQ_ST:0]   sv_r;
  tun_job_t         sj_r  [SQ_ST+1];
  logic [SUM_W-1:0] srad_r[SQ_ST+1];
  logic [REM_W-1:0] srem_r[SQ_ST+1];
  logic [ROOT_W-1:0] sroot_r[SQ_ST+1];

  always_comb begin
    sv_r[0]    = vb_r;
    sj_r[0]    = jb_r;
    srad_r[0]  = sum_r;
    srem_r[0]  = '0;
    sroot_r[0] = '0;
  end

  for (genvar s = 0; s < SQ_ST; s++) begin : g_sqrt
    logic [REM_W-1:0]  trial, rem_sh;
    logic [ROOT_W-1:0] r_nxt;
    logic [REM_W-1:0]  rem_nxt;
    always_comb begin
      rem_sh = {srem_r[s][REM_W-3:0], srad_r[s][SUM_W-1 -: 2]};
      trial  = {sroot_r[s], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt = rem_sh - trial;
        r_nxt   = {sroot_r[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        r_nxt   = {sroot_r[s][ROOT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s+1] <= 1'b0;
      end else if (en) begin
        sv_r[s+1] <= sv_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sj_r[s+1]    <= sj_r[s];
        srad_r[s+1]  <= {srad_r[s][SUM_W-3:0], 2'b00};
        srem_r[s+1]  <= rem_nxt;
        sroot_r[s+1] <= r_nxt;
      end
    end
  end

  // Division: numerator m*2^F + L/2 over L, one quotient bit per stage
  logic [DV_ST:0]    dv_r;
  tun_job_t          dj_r  [DV_ST+1];
  logic [ROOT_W-1:0] dl_r  [DV_ST+1];
  logic [DVD_W-1:0]  dn_r  [DV_ST+1][3];
  logic [ROOT_W:0]   drm_r [DV_ST+1][3];
  logic [QUO_W-1:0]  dq_r  [DV_ST+1][3];

  logic [NORM_BITS-1:0] sm [3];
  always_comb begin
    sm[0] = sj_r[SQ_ST].mx;
    sm[1] = sj_r[SQ_ST].my;
    sm[2] = sj_r[SQ_ST].mz;
    dv_r[0] = sv_r[SQ_ST];
    dj_r[0] = sj_r[SQ_ST];
    dl_r[0] = sroot_r[SQ_ST];
    for (int i = 0; i < 3; i++) begin
      dn_r[0][i]  = DVD_W'({sm[i], {NORMAL_FRAC_BITS{1'b0}}})
                  + DVD_W'(sroot_r[SQ_ST] >> 1);
      drm_r[0][i] = '0;
      dq_r[0][i]  = '0;
    end
  end

  for (genvar s = 0; s < DV_ST; s++) begin : g_div
    logic [ROOT_W:0]  rsh [3];
    logic [ROOT_W:0]  rnx [3];
    logic [2:0]       qb;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i] = {drm_r[s][i][ROOT_W-1:0], dn_r[s][i][DVD_W-1-s]};
        qb[i]  = (rsh[i] >= {1'b0, dl_r[s]});
        rnx[i] = qb[i] ? rsh[i] - {1'b0, dl_r[s]} : rsh[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_r[s+1] <= dv_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dj_r[s+1] <= dj_r[s];
        dl_r[s+1] <= dl_r[s];
        for (int i = 0; i < 3; i++) begin
          dn_r[s+1][i]  <= dn_r[s][i];
          drm_r[s+1][i] <= rnx[i];
          dq_r[s+1][i]  <= {dq_r[s][i][QUO_W-2:0], qb[i]};
        end
      end
    end
  end

  // Sign, saturate and register the result
  function automatic logic [15:0] fin(input logic [QUO_W-1:0] q, input logic ng);
    logic [QUO_W-1:0] qs;
    qs = q;
    if (ng) begin
      if (qs > QUO_W'(32768)) qs = QUO_W'(32768);
      return 16'(-qs);
    end else begin
      if (qs > QUO_W'(32767)) qs = QUO_W'(32767);
      return 16'(qs);
    end
  endfunction

  logic     ov_r;
  tun_out_t or_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_r[DV_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      or_r.result_tag <= dj_r[DV_ST].tag;
      or_r.degenerate <= dj_r[DV_ST].degenerate;
      if (dj_r[DV_ST].degenerate) begin
        or_r.normal_x <= '0;
        or_r.normal_y <= '0;
        or_r.normal_z <= '0;
      end else begin
        or_r.normal_x <= fin(dq_r[DV_ST][0], dj_r[DV_ST].neg[0]);
        or_r.normal_y <= fin(dq_r[DV_ST][1], dj_r[DV_ST].neg[1]);
        or_r.normal_z <= fin(dq_r[DV_ST][2], dj_r[DV_ST].neg[2]);
      end
    end
  end

  assign res_vld = ov_r;
  assign res     = or_r;

  property p_degen_zero;
    @(posedge clk) disable iff (!rst_n)
      (res_vld && res.degenerate) |-> (res.normal_x == 0 && res.normal_y == 0 && res.normal_z == 0);
  endproperty
  a_degen_zero: assert property (p_degen_zero) else $error("degenerate normal not zero");

  property p_hold;
    @(posedge clk) disable iff (!rst_n) !en |=> $stable(ov_r);
  endproperty
  a_hold: assert property (p_hold) else $error("back pipeline moved while stalled");

  property p_len;
    @(posedge clk) disable iff (!rst_n)
      (dv_r[0] && !dj_r[0].degenerate) |-> dl_r[0] != '0;
  endproperty
  a_len: assert property (p_len) else $error("zero length on live triangle");

endmodule : tun_back
`default_nettype wire

// ----- rtl/core/triangle_unit_normal.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of one triangle per request
// Front pipeline (5 stages) forms the cross product and normalizes it; an
// 8-entry queue decouples it from the back pipeline (sqrt and divide).
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not stalled.
// Stages: 5 front stages, the queue, then 2 + 31 sqrt + 45 divide + 1 output
//   stages in the back; the back pipeline freezes while its result is
//   stalled, and the input stalls once queue plus front hold 8 requests.
// Reset: synchronous active-low rst_n clears all valid bits and the queue.
// ----------------------------------------------------------------------------
module triangle_unit_normal (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tun_pkg::tun_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tun_pkg::tun_out_t      out_data
);
  import tun_pkg::*;

  logic             job_vld, q_vld, back_en, front_en, q_rd;
  tun_job_t         job, q_data;
  logic [FIFO_AW:0] q_cnt;
  logic [FIFO_AW:0] q_infl;

  // Count front items in flight plus queued so the queue never overflows
  logic [2:0] fl_r;
  logic       acc;
  assign acc      = in_valid && !in_stall;
  assign front_en = 1'b1;
  assign in_stall = ({1'b0, q_cnt} + {1'b0, q_infl}) >= (FIFO_AW+2)'(FIFO_DEPTH);

  tun_fifo u_fifo (
    .clk, .rst_n,
    .wr_en(job_vld), .wr_data(job),
    .rd_en(q_rd), .rd_vld(q_vld), .rd_data(q_data), .count(q_cnt)
  );

  tun_front u_front (
    .clk, .rst_n, .en(front_en),
    .in_vld(acc), .in_data,
    .job_vld, .job
  );

  assign back_en = !(out_valid && out_stall);
  assign q_rd    = back_en && q_vld;

  tun_back u_back (
    .clk, .rst_n, .en(back_en),
    .job_vld(q_rd), .job(q_data),
    .res_vld(out_valid), .res(out_data)
  );

  // Track items inside the front pipeline
  logic [4:0] fv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      fl_r <= '0;
    end else begin
      fv_r <= {fv_r[3:0], acc};
      fl_r <= fl_r + 3'(acc) - 3'(job_vld);
    end
  end
  assign q_infl = (FIFO_AW+1)'(fl_r);

  property p_front_match;
    @(posedge clk) disable iff (!rst_n) fv_r[4] |-> job_vld;
  endproperty
  a_front_match: assert property (p_front_match) else $error("front valid lost");

  property p_stall_hold;
    @(posedge clk) disable iff (!rst_n) (out_valid && out_stall) |=> out_valid;
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("stalled result dropped");

  property p_fill;
    @(posedge clk) disable iff (!rst_n) 32'(q_cnt) + 32'(fl_r) <= FIFO_DEPTH;
  endproperty
  a_fill: assert property (p_fill) else $error("credit overrun");

endmodule : triangle_unit_normal
`default_nettype wire
